// ===== rtl/cmpc_pkg.sv =====
// Shared types, constants and helpers for the cascaded motor controller.
`timescale 1ns / 1ps
`default_nettype none
package cmpc_pkg;

    localparam int LOG_DEPTH_DEF  = 128;
    localparam int PWM_PERIOD_DEF = 2399;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_KP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_KI     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_KP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_KI    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_KD    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_LOOP_DUTY = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ANGLE   = 3'd6;

    localparam logic [15:0] CURRENT_KP_RST  = 16'd410;
    localparam logic [15:0] CURRENT_KI_RST  = 16'd287;
    localparam logic [15:0] POSITION_KP_RST = 16'd2867;
    localparam logic [15:0] POSITION_KI_RST = 16'd0;
    localparam logic [15:0] POSITION_KD_RST = 16'd410;

    localparam logic signed [15:0] COMMAND_RST = 16'sd5;
    localparam logic signed [15:0] TEST_AMPL   = 16'sd200;
    localparam logic signed [7:0]  DUTY_LIMIT  = 8'sd100;
    localparam logic signed [63:0] DRIVE_LIMIT = 64'sd409600;

    // floor(x / 25) = (x * R25) >> 24 for x below 2^17
    localparam logic signed [27:0] R25 = 28'sd671089;
    // floor(x / 35) = (x * R35) >> 32 for x below 2^27
    localparam logic signed [27:0] R35 = 28'sd122713352;

    typedef enum logic [2:0] {
        RM_IDLE  = 3'd0,
        RM_PWM   = 3'd1,
        RM_ITEST = 3'd2,
        RM_HOLD  = 3'd3,
        RM_TRACK = 3'd4
    } run_mode_t;

    typedef enum logic [1:0] {
        IM_CURRENT  = 2'd0,
        IM_POSITION = 2'd1,
        IM_SET_MODE = 2'd2,
        IM_READ_LOG = 2'd3
    } item_mode_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_DRV_OFF,
        OP_C_ERR,
        OP_C_MP,
        OP_C_MI,
        OP_C_CLAMP,
        OP_OL_MAG,
        OP_D_MUL,
        OP_D_DIV,
        OP_D_FIN,
        OP_P_NUM,
        OP_P_DIV,
        OP_P_E,
        OP_P_M1,
        OP_P_M2,
        OP_P_M3,
        OP_P_FIN,
        OP_SET_MODE,
        OP_LOG_RD
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_DRV_OFF,
        ST_C_ERR,
        ST_C_MP,
        ST_C_MI,
        ST_C_CLAMP,
        ST_OL_MAG,
        ST_D_MUL,
        ST_D_DIV,
        ST_D_FIN,
        ST_P_NUM,
        ST_P_DIV,
        ST_P_E,
        ST_P_M1,
        ST_P_M2,
        ST_P_M3,
        ST_P_FIN,
        ST_SET_MODE,
        ST_LOG_RD,
        ST_RESP
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
        logic   take;
        logic   emit;
    } cmd_t;

    typedef struct packed {
        item_mode_t item_mode;
        run_mode_t  run_mode;
    } status_t;

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31])
        begin
            r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/cmpc_in_if.sv =====
// Input channel interface: tick, mode change and log read transactions.
`timescale 1ns / 1ps
`default_nettype none
interface cmpc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic signed [15:0] current_sample;
    logic signed [23:0] encoder_count;
    logic [2:0]         new_run_mode;
    logic [6:0]         log_index;

    modport source (output valid, mode, current_sample, encoder_count, new_run_mode,
                    log_index, input ready);
    modport sink (input valid, mode, current_sample, encoder_count, new_run_mode,
                  log_index, output ready);
endinterface
`default_nettype wire

// ===== rtl/cmpc_out_if.sv =====
// Output channel interface: one result transaction per input transaction.
`timescale 1ns / 1ps
`default_nettype none
interface cmpc_out_if;
    logic               valid;
    logic               ready;
    logic [11:0]        pwm_compare;
    logic               direction;
    logic [2:0]         run_mode_now;
    logic signed [15:0] current_command;
    logic signed [15:0] logged_current;
    logic signed [15:0] logged_reference;
    logic               test_done;

    modport source (output valid, pwm_compare, direction, run_mode_now, current_command,
                    logged_current, logged_reference, test_done, input ready);
    modport sink (input valid, pwm_compare, direction, run_mode_now, current_command,
                  logged_current, logged_reference, test_done, output ready);
endinterface
`default_nettype wire

// ===== rtl/cmpc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module cmpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic                             re,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output logic      [WIDTH-1:0]                 rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/cmpc_ctrl.sv =====
// Controller state machine: sequences the datapath for each transaction.
`timescale 1ns / 1ps
`default_nettype none
module cmpc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire cmpc_pkg::status_t status,
    output cmpc_pkg::cmd_t         cmd
);
    import cmpc_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        cmd        = '{op: OP_NONE, take: 1'b0, emit: 1'b0};
        state_next = state_reg;
        in_ready   = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (status.item_mode)
                    IM_CURRENT:
                    begin
                        if (status.run_mode == RM_IDLE)
                        begin
                            state_next = ST_DRV_OFF;
                        end
                        else if (status.run_mode == RM_PWM)
                        begin
                            state_next = ST_OL_MAG;
                        end
                        else if (status.run_mode inside {RM_ITEST, RM_HOLD})
                        begin
                            state_next = ST_C_ERR;
                        end
                        else
                        begin
                            state_next = ST_RESP;
                        end
                    end
                    IM_POSITION:
                    begin
                        state_next = (status.run_mode == RM_HOLD) ? ST_P_NUM : ST_RESP;
                    end
                    IM_SET_MODE: state_next = ST_SET_MODE;
                    IM_READ_LOG: state_next = ST_LOG_RD;
                    default:     state_next = ST_RESP;
                endcase
            end
            ST_DRV_OFF:  begin cmd.op = OP_DRV_OFF;  state_next = ST_RESP;    end
            ST_C_ERR:    begin cmd.op = OP_C_ERR;    state_next = ST_C_MP;    end
            ST_C_MP:     begin cmd.op = OP_C_MP;     state_next = ST_C_MI;    end
            ST_C_MI:     begin cmd.op = OP_C_MI;     state_next = ST_C_CLAMP; end
            ST_C_CLAMP:  begin cmd.op = OP_C_CLAMP;  state_next = ST_D_MUL;   end
            ST_OL_MAG:   begin cmd.op = OP_OL_MAG;   state_next = ST_D_MUL;   end
            ST_D_MUL:    begin cmd.op = OP_D_MUL;    state_next = ST_D_DIV;   end
            ST_D_DIV:    begin cmd.op = OP_D_DIV;    state_next = ST_D_FIN;   end
            ST_D_FIN:    begin cmd.op = OP_D_FIN;    state_next = ST_RESP;    end
            ST_P_NUM:    begin cmd.op = OP_P_NUM;    state_next = ST_P_DIV;   end
            ST_P_DIV:    begin cmd.op = OP_P_DIV;    state_next = ST_P_E;     end
            ST_P_E:      begin cmd.op = OP_P_E;      state_next = ST_P_M1;    end
            ST_P_M1:     begin cmd.op = OP_P_M1;     state_next = ST_P_M2;    end
            ST_P_M2:     begin cmd.op = OP_P_M2;     state_next = ST_P_M3;    end
            ST_P_M3:     begin cmd.op = OP_P_M3;     state_next = ST_P_FIN;   end
            ST_P_FIN:    begin cmd.op = OP_P_FIN;    state_next = ST_RESP;    end
            ST_SET_MODE: begin cmd.op = OP_SET_MODE; state_next = ST_RESP;    end
            ST_LOG_RD:   begin cmd.op = OP_LOG_RD;   state_next = ST_RESP;    end
            ST_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
endmodule
`default_nettype wire

// ===== rtl/cmpc_dp.sv =====
// Datapath: loop state, shared multiplier, sample log and result register.
`timescale 1ns / 1ps
`default_nettype none
module cmpc_dp #(
    parameter int LOG_DEPTH  = cmpc_pkg::LOG_DEPTH_DEF,
    parameter int PWM_PERIOD = cmpc_pkg::PWM_PERIOD_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire cmpc_pkg::cmd_t                    cmd,
    output cmpc_pkg::status_t                      status,
    input  wire logic                              cfg_we,
    input  wire logic [cmpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [cmpc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [1:0]                        in_mode,
    input  wire logic signed [15:0]                in_current_sample,
    input  wire logic signed [23:0]                in_encoder_count,
    input  wire logic [2:0]                        in_new_run_mode,
    input  wire logic [6:0]                        in_log_index,
    output logic [11:0]                            pwm_compare,
    output logic                                   direction,
    output logic [2:0]                             run_mode_now,
    output logic signed [15:0]                     current_command,
    output logic signed [15:0]                     logged_current,
    output logic signed [15:0]                     logged_reference,
    output logic                                   test_done
);
    import cmpc_pkg::*;

    localparam int AW = $clog2(LOG_DEPTH);
    localparam logic [AW-1:0] LAST   = AW'(LOG_DEPTH - 1);
    localparam logic [AW:0]   Q1     = (AW+1)'(LOG_DEPTH / 4);
    localparam logic [AW:0]   Q2     = (AW+1)'(LOG_DEPTH / 2);
    localparam logic [AW:0]   Q3     = (AW+1)'(3 * LOG_DEPTH / 4);
    localparam logic [7:0]    DEPTH8 = 8'(LOG_DEPTH);

    // configuration
    logic [15:0]        ckp_reg, cki_reg, pkp_reg, pki_reg, pkd_reg;
    logic signed [7:0]  duty_reg;
    logic signed [15:0] tangle_reg;

    // loop state
    run_mode_t          run_mode_reg;
    logic signed [31:0] cint_reg, pint_reg;
    logic signed [15:0] prev_reg, ccmd_reg;
    logic [AW-1:0]      tcnt_reg, hcnt_reg;
    logic [11:0]        cmp_reg;
    logic               dir_reg;
    logic               done_reg;

    // latched transaction
    logic [1:0]         mode_reg;
    logic signed [15:0] sample_reg;
    logic signed [23:0] enc_reg;
    logic [2:0]         nrm_reg;
    logic [6:0]         lidx_reg;
    logic               lidx_ok_reg;

    // work registers
    logic signed [17:0] err_reg;
    logic signed [15:0] ref_reg;
    logic signed [63:0] acc_reg;
    logic [31:0]        mag_reg;
    logic               sign_reg;
    logic signed [15:0] e_reg;
    logic signed [16:0] diff_reg;

    // result register
    logic [11:0]        out_cmp_reg;
    logic               out_dir_reg;
    logic [2:0]         out_rm_reg;
    logic signed [15:0] out_cmd_reg, out_lcur_reg, out_lref_reg;
    logic               out_done_reg;

    // shared multiplier
    logic signed [32:0] mul_a;
    logic signed [27:0] mul_b;
    logic signed [60:0] mul_p;

    logic [31:0]        dsh;
    logic signed [15:0] ref_w;
    logic signed [17:0] err_w;
    logic signed [33:0] num_w, num_mag;
    logic [21:0]        q_w;
    logic signed [15:0] e_w;
    logic signed [63:0] t_w;
    logic signed [15:0] cmd_w;
    logic [12:0]        cq_w;
    logic               log_mode;

    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr;
    logic [31:0]        ram_rdata;

    assign status.item_mode = item_mode_t'(mode_reg);
    assign status.run_mode  = run_mode_reg;

    assign log_mode = (run_mode_reg == RM_ITEST) || (run_mode_reg == RM_HOLD);
    assign dsh      = (run_mode_reg == RM_PWM) ? acc_reg[33:2] : acc_reg[45:14];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_C_MP: begin mul_a = 33'(err_reg);  mul_b = $signed({12'b0, ckp_reg}); end
            OP_C_MI: begin mul_a = 33'(cint_reg); mul_b = $signed({12'b0, cki_reg}); end
            OP_D_MUL:
            begin
                mul_a = $signed({1'b0, mag_reg});
                mul_b = (run_mode_reg == RM_PWM) ? 28'(PWM_PERIOD + 1) : 28'(PWM_PERIOD);
            end
            OP_D_DIV: begin mul_a = $signed({1'b0, dsh});     mul_b = R25; end
            OP_P_DIV: begin mul_a = $signed({1'b0, mag_reg}); mul_b = R35; end
            OP_P_M1: begin mul_a = 33'(e_reg);    mul_b = $signed({12'b0, pkp_reg}); end
            OP_P_M2: begin mul_a = 33'(pint_reg); mul_b = $signed({12'b0, pki_reg}); end
            OP_P_M3: begin mul_a = 33'(diff_reg); mul_b = $signed({12'b0, pkd_reg}); end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        if (run_mode_reg == RM_HOLD)
        begin
            ref_w = ccmd_reg;
        end
        else if ({1'b0, tcnt_reg} < Q1)
        begin
            ref_w = TEST_AMPL;
        end
        else if ({1'b0, tcnt_reg} < Q2)
        begin
            ref_w = -TEST_AMPL;
        end
        else if ({1'b0, tcnt_reg} < Q3)
        begin
            ref_w = TEST_AMPL;
        end
        else
        begin
            ref_w = -TEST_AMPL;
        end
    end

    assign err_w   = 18'(sample_reg) - 18'(ref_w);
    assign num_w   = 34'(tangle_reg) * 34'sd35 - 34'(enc_reg) * 34'sd144;
    assign num_mag = num_w[33] ? -num_w : num_w;
    assign q_w     = acc_reg[53:32];
    assign cq_w    = acc_reg[36:24];

    always_comb
    begin
        if (sign_reg)
        begin
            e_w = (q_w > 22'd32768) ? 16'sh8000 : 16'(-$signed({1'b0, q_w}));
        end
        else
        begin
            e_w = (q_w > 22'd32767) ? 16'sh7fff : 16'(q_w);
        end
    end

    always_comb
    begin
        t_w = acc_reg[63] ? ((acc_reg + 64'sd4095) >>> 12) : (acc_reg >>> 12);
        if (t_w > 64'sd32767)
        begin
            cmd_w = 16'sh7fff;
        end
        else if (t_w < -64'sd32768)
        begin
            cmd_w = 16'sh8000;
        end
        else
        begin
            cmd_w = t_w[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ckp_reg      <= CURRENT_KP_RST;
            cki_reg      <= CURRENT_KI_RST;
            pkp_reg      <= POSITION_KP_RST;
            pki_reg      <= POSITION_KI_RST;
            pkd_reg      <= POSITION_KD_RST;
            duty_reg     <= '0;
            tangle_reg   <= '0;
            run_mode_reg <= RM_IDLE;
            cint_reg     <= '0;
            pint_reg     <= '0;
            prev_reg     <= '0;
            ccmd_reg     <= COMMAND_RST;
            tcnt_reg     <= '0;
            hcnt_reg     <= '0;
            cmp_reg      <= '0;
            dir_reg      <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CURRENT_KP:     ckp_reg    <= cfg_data;
                    CFG_CURRENT_KI:     cki_reg    <= cfg_data;
                    CFG_POSITION_KP:    pkp_reg    <= cfg_data;
                    CFG_POSITION_KI:    pki_reg    <= cfg_data;
                    CFG_POSITION_KD:    pkd_reg    <= cfg_data;
                    CFG_OPEN_LOOP_DUTY: duty_reg   <= cfg_data[7:0];
                    CFG_TARGET_ANGLE:   tangle_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.take)
            begin
                done_reg <= 1'b0;
            end
            case (cmd.op)
                OP_DRV_OFF:
                begin
                    cmp_reg <= '0;
                    dir_reg <= 1'b0;
                end
                OP_C_ERR:
                begin
                    cint_reg <= sat32(33'(cint_reg) + 33'(err_w));
                end
                OP_D_FIN:
                begin
                    cmp_reg <= (cq_w > 13'd4095) ? 12'd4095 : cq_w[11:0];
                    dir_reg <= sign_reg;
                    if (run_mode_reg == RM_ITEST)
                    begin
                        if (tcnt_reg == LAST)
                        begin
                            tcnt_reg     <= '0;
                            cint_reg     <= '0;
                            run_mode_reg <= RM_IDLE;
                            done_reg     <= 1'b1;
                        end
                        else
                        begin
                            tcnt_reg <= tcnt_reg + 1'b1;
                        end
                    end
                    else if (run_mode_reg == RM_HOLD)
                    begin
                        if (hcnt_reg == LAST)
                        begin
                            hcnt_reg <= '0;
                            cint_reg <= '0;
                        end
                        else
                        begin
                            hcnt_reg <= hcnt_reg + 1'b1;
                        end
                    end
                end
                OP_P_E:
                begin
                    pint_reg <= sat32(33'(pint_reg) + 33'(e_w));
                end
                OP_P_FIN:
                begin
                    ccmd_reg <= cmd_w;
                    prev_reg <= e_reg;
                end
                OP_SET_MODE:
                begin
                    if (nrm_reg <= 3'(RM_TRACK))
                    begin
                        run_mode_reg <= run_mode_t'(nrm_reg);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            mode_reg   <= in_mode;
            sample_reg <= in_current_sample;
            enc_reg    <= in_encoder_count;
            nrm_reg    <= in_new_run_mode;
            lidx_reg   <= in_log_index;
        end
        case (cmd.op)
            OP_C_ERR:
            begin
                err_reg <= err_w;
                ref_reg <= ref_w;
            end
            OP_C_MP, OP_D_MUL, OP_D_DIV, OP_P_DIV, OP_P_M1:
            begin
                acc_reg <= 64'(mul_p);
            end
            OP_C_MI, OP_P_M2, OP_P_M3:
            begin
                acc_reg <= acc_reg + 64'(mul_p);
            end
            OP_C_CLAMP:
            begin
                sign_reg <= acc_reg[63];
                if ((acc_reg > DRIVE_LIMIT) || (acc_reg < -DRIVE_LIMIT))
                begin
                    mag_reg <= DRIVE_LIMIT[31:0];
                end
                else
                begin
                    mag_reg <= acc_reg[63] ? 32'(-acc_reg) : acc_reg[31:0];
                end
            end
            OP_OL_MAG:
            begin
                sign_reg <= duty_reg[7];
                if ((duty_reg > DUTY_LIMIT) || (duty_reg < -DUTY_LIMIT))
                begin
                    mag_reg <= 32'(DUTY_LIMIT);
                end
                else
                begin
                    mag_reg <= duty_reg[7] ? 32'(-duty_reg) : 32'(duty_reg);
                end
            end
            OP_P_NUM:
            begin
                sign_reg <= num_w[33];
                mag_reg  <= 32'(num_mag[33:4]);
            end
            OP_P_E:
            begin
                e_reg    <= e_w;
                diff_reg <= 17'(e_w) - 17'(prev_reg);
            end
            OP_LOG_RD:
            begin
                lidx_ok_reg <= ({1'b0, lidx_reg} < DEPTH8);
            end
            default: ;
        endcase
        if (cmd.emit)
        begin
            out_cmp_reg  <= cmp_reg;
            out_dir_reg  <= dir_reg;
            out_rm_reg   <= run_mode_reg;
            out_cmd_reg  <= ccmd_reg;
            out_done_reg <= done_reg;
            if ((mode_reg == IM_READ_LOG) && lidx_ok_reg)
            begin
                out_lcur_reg <= ram_rdata[31:16];
                out_lref_reg <= ram_rdata[15:0];
            end
            else
            begin
                out_lcur_reg <= '0;
                out_lref_reg <= '0;
            end
        end
    end

    assign ram_we    = (cmd.op == OP_D_FIN) && log_mode;
    assign ram_waddr = (run_mode_reg == RM_ITEST) ? tcnt_reg : hcnt_reg;
    assign ram_re    = (cmd.op == OP_LOG_RD);

    cmpc_ram #(
        .WIDTH (32),
        .DEPTH (LOG_DEPTH)
    ) u_log (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({sample_reg, ref_reg}),
        .re    (ram_re),
        .raddr (lidx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign pwm_compare      = out_cmp_reg;
    assign direction        = out_dir_reg;
    assign run_mode_now     = out_rm_reg;
    assign current_command  = out_cmd_reg;
    assign logged_current   = out_lcur_reg;
    assign logged_reference = out_lref_reg;
    assign test_done        = out_done_reg;
endmodule
`default_nettype wire

// ===== rtl/cascaded_motor_pi_pid_controller_core.sv =====
// From accept to result valid: dispatch, work states, response. Closed-loop current ticks
// run error, multiplies, clamp and drive; open-loop ticks magnitude and drive; hold
// position ticks the position PID; idle ticks, mode changes and log reads their own step.
// One transaction at a time: the next input is taken the cycle after the result
// enters the output register; closed-loop multiplies run in turn on one shared multiplier.
// Reset is asynchronous; the sample log is not cleared and holds garbage until written.
`timescale 1ns / 1ps
`default_nettype none
module cascaded_motor_pi_pid_controller_core #(
    parameter int LOG_DEPTH  = cmpc_pkg::LOG_DEPTH_DEF,
    parameter int PWM_PERIOD = cmpc_pkg::PWM_PERIOD_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    cmpc_in_if.sink                              in_ch,
    cmpc_out_if.source                           out_ch,
    input  wire logic                            cfg_we,
    input  wire logic [cmpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cmpc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cmpc_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    in_ready;
    logic    out_valid;

    cmpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    cmpc_dp #(
        .LOG_DEPTH  (LOG_DEPTH),
        .PWM_PERIOD (PWM_PERIOD)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_mode           (in_ch.mode),
        .in_current_sample (in_ch.current_sample),
        .in_encoder_count  (in_ch.encoder_count),
        .in_new_run_mode   (in_ch.new_run_mode),
        .in_log_index      (in_ch.log_index),
        .pwm_compare       (out_ch.pwm_compare),
        .direction         (out_ch.direction),
        .run_mode_now      (out_ch.run_mode_now),
        .current_command   (out_ch.current_command),
        .logged_current    (out_ch.logged_current),
        .logged_reference  (out_ch.logged_reference),
        .test_done         (out_ch.test_done)
    );

    assign in_ch.ready  = in_ready;
    assign out_ch.valid = out_valid;
endmodule
`default_nettype wire

// ===== rtl/cmpc_checker.sv =====
// Port-level assertions for the motor controller core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module cmpc_port_props (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [11:0]        pwm_compare,
    input wire logic [2:0]         run_mode_now,
    input wire logic signed [15:0] current_command,
    input wire logic               test_done
);
    import cmpc_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pwm_compare)
            && $stable(current_command) && $stable(test_done))
        else $error("result changed or dropped while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction taken while one is in work");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared the cycle after accept");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && test_done |-> run_mode_now == RM_IDLE)
        else $error("test finished without returning to idle");
endmodule

bind cascaded_motor_pi_pid_controller_core cmpc_port_props u_cmpc_port_props (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .pwm_compare     (out_ch.pwm_compare),
    .run_mode_now    (out_ch.run_mode_now),
    .current_command (out_ch.current_command),
    .test_done       (out_ch.test_done)
);
`default_nettype wire

// ===== tb/sv/cmpc_checker.sv =====
// Checker for the motor controller core: predicts each result and compares it field by field.
`timescale 1ns / 1ps
`default_nettype none
module cmpc_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    cmpc_in_if                                   in_ch,
    cmpc_out_if                                  out_ch,
    input  wire logic                            cfg_we,
    input  wire logic [cmpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cmpc_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                                   fail_count,
    output int                                   pending,
    output int                                   done_count
);
    import cmpc_pkg::*;

    localparam int  DEPTH    = LOG_DEPTH_DEF;
    localparam int  PERIOD   = PWM_PERIOD_DEF;
    localparam longint LIMIT = 409600;

    typedef struct {
        logic [11:0]        cmp;
        logic               dir;
        logic [2:0]         rmode;
        logic signed [15:0] cmd;
        logic signed [15:0] lcur;
        logic signed [15:0] lref;
        logic               done;
    } drive_result_t;

    drive_result_t result_q[$];

    logic [15:0] cur_kp, cur_ki, pos_kp, pos_ki, pos_kd, target;
    logic [7:0]  duty;

    run_mode_t          rmode;
    longint             cur_acc, pos_acc, prev_err, cmd;
    int                 test_cnt, hold_cnt;
    logic signed [15:0] cur_log [DEPTH];
    logic signed [15:0] ref_log [DEPTH];
    logic [11:0]        drv_cmp;
    logic               drv_dir;

    assign pending = result_q.size();

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    task automatic run_current_pi(longint sample, longint ref_ma);
        longint err;
        longint u;
        longint mag;
        err = sample - ref_ma;
        cur_acc = clip(cur_acc + err, -64'sd2147483648, 64'sd2147483647);
        u = longint'(cur_kp) * err + longint'(cur_ki) * cur_acc;
        u = clip(u, -LIMIT, LIMIT);
        mag = u < 0 ? -u : u;
        mag = (mag * PERIOD) / LIMIT;
        drv_cmp = mag > 4095 ? 12'hfff : mag[11:0];
        drv_dir = u < 0;
    endtask

    task automatic predict_result(input logic [1:0] mode, input logic signed [15:0] sample,
                                  input logic signed [23:0] enc, input logic [2:0] nrm,
                                  input logic [6:0] idx);
        drive_result_t r;
        longint d;
        longint e;
        longint u;
        longint ref_ma;
        r.lcur = '0;
        r.lref = '0;
        r.done = 1'b0;
        case (item_mode_t'(mode))
            IM_CURRENT:
            begin
                case (rmode)
                    RM_IDLE:
                    begin
                        drv_cmp = '0;
                        drv_dir = 1'b0;
                    end
                    RM_PWM:
                    begin
                        d = clip(longint'($signed(duty)), -100, 100);
                        u = d < 0 ? -d : d;
                        u = u * (PERIOD + 1) / 100;
                        drv_cmp = u > 4095 ? 12'hfff : u[11:0];
                        drv_dir = d < 0;
                    end
                    RM_ITEST:
                    begin
                        ref_ma = (test_cnt < DEPTH / 4) ? 200 : (test_cnt < DEPTH / 2) ? -200 :
                                 (test_cnt < 3 * DEPTH / 4) ? 200 : -200;
                        run_current_pi(sample, ref_ma);
                        cur_log[test_cnt] = sample;
                        ref_log[test_cnt] = ref_ma[15:0];
                        test_cnt++;
                        if (test_cnt >= DEPTH)
                        begin
                            test_cnt = 0;
                            cur_acc = 0;
                            rmode = RM_IDLE;
                            r.done = 1'b1;
                            done_count++;
                        end
                    end
                    RM_HOLD:
                    begin
                        run_current_pi(sample, cmd);
                        cur_log[hold_cnt] = sample;
                        ref_log[hold_cnt] = cmd[15:0];
                        hold_cnt++;
                        if (hold_cnt >= DEPTH)
                        begin
                            hold_cnt = 0;
                            cur_acc = 0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            IM_POSITION:
            begin
                if (rmode == RM_HOLD)
                begin
                    e = (35 * longint'($signed(target)) - 144 * longint'(enc)) / 560;
                    e = clip(e, -32768, 32767);
                    pos_acc = clip(pos_acc + e, -64'sd2147483648, 64'sd2147483647);
                    u = longint'(pos_kp) * e + longint'(pos_ki) * pos_acc
                        + longint'(pos_kd) * (e - prev_err);
                    cmd = clip(u / 4096, -32768, 32767);
                    prev_err = e;
                end
            end
            IM_SET_MODE:
            begin
                if (nrm <= RM_TRACK)
                begin
                    rmode = run_mode_t'(nrm);
                end
            end
            default:
            begin
                if (idx < DEPTH)
                begin
                    r.lcur = cur_log[idx];
                    r.lref = ref_log[idx];
                end
            end
        endcase
        r.cmp = drv_cmp;
        r.dir = drv_dir;
        r.rmode = rmode;
        r.cmd = cmd[15:0];
        result_q.push_back(r);
    endtask

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            $display("%0t ERROR %s mismatch: expected %0d, actual %0d", $time, name, exp_v,
                     act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        drive_result_t r;
        if (!rst_n)
        begin
            cur_kp = CURRENT_KP_RST;
            cur_ki = CURRENT_KI_RST;
            pos_kp = POSITION_KP_RST;
            pos_ki = POSITION_KI_RST;
            pos_kd = POSITION_KD_RST;
            duty = '0;
            target = '0;
            rmode = RM_IDLE;
            cur_acc = 0;
            pos_acc = 0;
            prev_err = 0;
            cmd = COMMAND_RST;
            test_cnt = 0;
            hold_cnt = 0;
            drv_cmp = '0;
            drv_dir = 1'b0;
            result_q.delete();
            fail_count = 0;
            done_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CURRENT_KP:     cur_kp = cfg_data;
                    CFG_CURRENT_KI:     cur_ki = cfg_data;
                    CFG_POSITION_KP:    pos_kp = cfg_data;
                    CFG_POSITION_KI:    pos_ki = cfg_data;
                    CFG_POSITION_KD:    pos_kd = cfg_data;
                    CFG_OPEN_LOOP_DUTY: duty = cfg_data[7:0];
                    CFG_TARGET_ANGLE:   target = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (result_q.size() == 0)
                begin
                    $display("%0t ERROR result with no expectation waiting", $time);
                    fail_count++;
                end
                else
                begin
                    r = result_q.pop_front();
                    check_field("pwm_compare", r.cmp, out_ch.pwm_compare);
                    check_field("direction", r.dir, out_ch.direction);
                    check_field("run_mode_now", r.rmode, out_ch.run_mode_now);
                    check_field("current_command", r.cmd, out_ch.current_command);
                    check_field("logged_current", r.lcur, out_ch.logged_current);
                    check_field("logged_reference", r.lref, out_ch.logged_reference);
                    check_field("test_done", r.done, out_ch.test_done);
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                predict_result(in_ch.mode, in_ch.current_sample, in_ch.encoder_count,
                               in_ch.new_run_mode, in_ch.log_index);
            end
        end
    end

endmodule
`default_nettype wire

// ===== tb/sv/tb_cascaded_motor_pi_pid_controller_core.sv =====
// Testbench top for the motor controller core: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_cascaded_motor_pi_pid_controller_core;
    import cmpc_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    done_count;
    int                    send_idle_pct;
    int                    recv_idle_pct;
    int                    sent;
    int                    settings;

    cmpc_in_if  in_if ();
    cmpc_out_if out_if ();

    cascaded_motor_pi_pid_controller_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_if),
        .out_ch   (out_if),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    cmpc_checker u_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_if),
        .out_ch    (out_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fail_count(fail_count),
        .pending   (pending),
        .done_count(done_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send(logic [1:0] mode, logic signed [15:0] sample, logic signed [23:0] enc,
                        logic [2:0] nrm, logic [6:0] idx);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.mode <= mode;
        in_if.current_sample <= sample;
        in_if.encoder_count <= enc;
        in_if.new_run_mode <= nrm;
        in_if.log_index <= idx;
        @(negedge clk);
        while (!in_if.ready)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        sent++;
        if (sent == 140)
        begin
            send_idle_pct = 48;
            recv_idle_pct = 38;
        end
        if (sent == 280)
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic configure(logic [15:0] ckp, logic [15:0] cki, logic [15:0] pkp,
                             logic [15:0] pki, logic [15:0] pkd, logic [7:0] duty,
                             logic [15:0] angle);
        drain();
        write_reg(CFG_CURRENT_KP, ckp);
        write_reg(CFG_CURRENT_KI, cki);
        write_reg(CFG_POSITION_KP, pkp);
        write_reg(CFG_POSITION_KI, pki);
        write_reg(CFG_POSITION_KD, pkd);
        write_reg(CFG_OPEN_LOOP_DUTY, {8'h00, duty});
        write_reg(CFG_TARGET_ANGLE, angle);
        cfg_we <= 1'b0;
        @(posedge clk);
        settings++;
    endtask

    task automatic change_run_mode(run_mode_t m);
        send(IM_SET_MODE, 16'($urandom), 24'($urandom), m, 7'($urandom));
    endtask

    task automatic tick_current(logic signed [15:0] sample);
        send(IM_CURRENT, sample, 24'($urandom), 3'($urandom), 7'($urandom));
    endtask

    task automatic tick_position(logic signed [23:0] enc);
        send(IM_POSITION, 16'($urandom), enc, 3'($urandom), 7'($urandom));
    endtask

    task automatic read_log(logic [6:0] idx);
        send(IM_READ_LOG, 16'($urandom), 24'($urandom), 3'($urandom), idx);
    endtask

    function automatic logic signed [15:0] near_ma(int span);
        return 16'($signed($urandom_range(2 * span)) - span);
    endfunction

    function automatic logic signed [23:0] encoder_value();
        if ($urandom_range(9) == 0)
        begin
            return 24'($urandom);
        end
        return 24'($signed($urandom_range(8000)) - 4000);
    endfunction

    task automatic run_test_fill();
        change_run_mode(RM_ITEST);
        repeat (LOG_DEPTH_DEF) tick_current(near_ma(400));
    endtask

    task automatic random_gains();
        configure($urandom_range(4) == 0 ? 16'hffff : 16'($urandom_range(2000)),
                  $urandom_range(4) == 0 ? 16'h0000 : 16'($urandom_range(1000)),
                  16'($urandom_range(8000)), 16'($urandom_range(500)),
                  16'($urandom_range(3000)), 8'($urandom), 16'($urandom));
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.mode = '0;
        in_if.current_sample = '0;
        in_if.encoder_count = '0;
        in_if.new_run_mode = '0;
        in_if.log_index = '0;
        out_if.ready = 1'b0;
        send_idle_pct = 38;
        recv_idle_pct = 48;
        sent = 0;
        settings = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        configure(16'd410, 16'd287, 16'd2867, 16'd0, 16'd410, -8'sd100, 16'd160);
        tick_current(16'sh7fff);
        change_run_mode(RM_PWM);
        tick_current(16'sh8000);
        change_run_mode(RM_TRACK);
        tick_current(16'sd1000);
        change_run_mode(RM_HOLD);
        tick_position(24'sh7fffff);
        tick_current(16'sh7fff);
        tick_position(24'sh800000);
        tick_current(16'sh8000);
        tick_position(24'sd0);
        tick_current(16'sd0);
        send(IM_SET_MODE, '0, '0, 3'd5, '0);
        send(IM_SET_MODE, '0, '0, 3'd7, '0);
        change_run_mode(RM_IDLE);
        tick_position(24'sd700);
        tick_current(16'sd50);
        configure(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'sd100, 16'h7fff);
        change_run_mode(RM_PWM);
        tick_current(16'sd0);
        change_run_mode(RM_HOLD);
        tick_position(24'sh800000);
        tick_current(16'sh8000);
        configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'h80, 16'h8000);
        change_run_mode(RM_PWM);
        tick_current(16'sd0);
        configure(16'd410, 16'd287, 16'd2867, 16'd100, 16'd410, 8'h7f, 16'd0);
        change_run_mode(RM_PWM);
        tick_current(16'sd0);
        run_test_fill();
        read_log(7'd0);
        read_log(7'd127);

        drain();
        while (sent < 230)
        begin
            random_gains();
            repeat (4)
            begin
                case ($urandom_range(9))
                    0, 1, 2, 3:
                    begin
                        change_run_mode(RM_HOLD);
                        repeat ($urandom_range(4, 20))
                        begin
                            tick_position(encoder_value());
                            repeat ($urandom_range(1, 3)) tick_current(near_ma(600));
                            if ($urandom_range(3) == 0)
                            begin
                                read_log(7'($urandom));
                            end
                        end
                    end
                    4:
                    begin
                        change_run_mode(RM_ITEST);
                        repeat ($urandom_range(5, 40)) tick_current(near_ma(500));
                        read_log(7'($urandom));
                    end
                    5:
                    begin
                        change_run_mode(run_mode_t'($urandom_range(1) ? RM_PWM : RM_TRACK));
                        repeat ($urandom_range(2, 6)) tick_current(16'($urandom));
                    end
                    default:
                    begin
                        repeat ($urandom_range(3, 10))
                        begin
                            send(2'($urandom), 16'($urandom), 24'($urandom), 3'($urandom),
                                 7'($urandom));
                        end
                    end
                endcase
            end
        end
        drain();
        change_run_mode(RM_HOLD);
        repeat (140) tick_current(near_ma(300));
        repeat (8) read_log(7'($urandom));
        drain();
        repeat (50) @(posedge clk);

        $display("Covered %0d transactions over %0d register settings; %0d current tests filled.",
                 sent, settings, done_count);
        if (fail_count == 0 && pending == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire
